### rtl/core/slbc_pkg.sv
// Package for the status LED breathing controller.
// Holds widths, full scale, reset values, register indexes, UI and phase types.
// No dependencies.
package slbc_pkg;

   localparam int DUTY_WIDTH = 16;
   localparam int OUT_WIDTH  = 16;
   localparam logic [DUTY_WIDTH-1:0] FULL_SCALE = {DUTY_WIDTH{1'b1}};

   localparam logic [7:0] RAMP_TOP_RESET    = 8'd100;
   localparam logic [7:0] DUTY_STEP_RESET   = 8'd2;
   localparam logic [7:0] PEAK_HOLD_RESET   = 8'd50;
   localparam logic [7:0] BOTTOM_HOLD_RESET = 8'd50;

   typedef enum logic [1:0] {
      REG_RAMP_TOP    = 2'd0,
      REG_DUTY_STEP   = 2'd1,
      REG_PEAK_HOLD   = 2'd2,
      REG_BOTTOM_HOLD = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      UI_STANDBY = 2'd0,
      UI_ERROR   = 2'd1,
      UI_MENU    = 2'd2,
      UI_RUNNING = 2'd3
   } ui_state_type;

   typedef enum logic [1:0] {
      PH_UP     = 2'd0,
      PH_PEAK   = 2'd1,
      PH_DOWN   = 2'd2,
      PH_BOTTOM = 2'd3
   } breath_phase_type;

endpackage

### rtl/core/status_led_breathing_controller.sv
// Status LED breathing controller top level.
// Takes one tick transaction per cycle unless stalled and returns the held blue and orange duties.
// Depends on slbc_pkg.
//
// Each tick transaction yields exactly one result transaction. A tick is
// captured in an input register, then the color choice, the breathing phase
// step and the duty product (intensity times duty_step, saturated at full
// scale) are resolved in one pass into the level registers, which drive the
// result ports. A new tick is accepted every cycle while the result side takes results.
// Configuration registers (ramp_top, duty_step, peak_hold_ticks,
// bottom_hold_ticks) sit at byte addresses 0, 4, 8 and 12 and should only
// be written while no tick is in flight.
module status_led_breathing_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_ui_state,
   input  logic        req_is_running,
   input  logic        req_at_temp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_blue_duty,
   output logic [15:0] rsp_orange_duty,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DW = slbc_pkg::DUTY_WIDTH;

   logic [7:0] ramp_top_ff, duty_step_ff, peak_hold_ff, bottom_hold_ff;

   logic       in_valid_ff;
   logic [1:0] in_state_ff;
   logic       in_running_ff, in_at_temp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   slbc_pkg::breath_phase_type phase_ff, phase_in;
   logic [7:0]    hold_ff, hold_in;
   logic [7:0]    intensity_ff, intensity_in;
   logic [DW-1:0] blue_ff, blue_in, orange_ff, orange_in;

   logic          advance, take;
   logic          csr_write;
   logic [1:0]    csr_index;
   logic          breathing, purple;
   logic [15:0]   product;
   logic [DW-1:0] duty;
   logic [7:0]    hold_mid;

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      unique case (slbc_pkg::reg_index_type'(csr_index))
         slbc_pkg::REG_RAMP_TOP:    csr_prdata = {24'd0, ramp_top_ff};
         slbc_pkg::REG_DUTY_STEP:   csr_prdata = {24'd0, duty_step_ff};
         slbc_pkg::REG_PEAK_HOLD:   csr_prdata = {24'd0, peak_hold_ff};
         slbc_pkg::REG_BOTTOM_HOLD: csr_prdata = {24'd0, bottom_hold_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_top_ff    <= slbc_pkg::RAMP_TOP_RESET;
         duty_step_ff   <= slbc_pkg::DUTY_STEP_RESET;
         peak_hold_ff   <= slbc_pkg::PEAK_HOLD_RESET;
         bottom_hold_ff <= slbc_pkg::BOTTOM_HOLD_RESET;
      end else if (csr_write) begin
         unique case (slbc_pkg::reg_index_type'(csr_index))
            slbc_pkg::REG_RAMP_TOP:    ramp_top_ff    <= csr_pwdata[7:0];
            slbc_pkg::REG_DUTY_STEP:   duty_step_ff   <= csr_pwdata[7:0];
            slbc_pkg::REG_PEAK_HOLD:   peak_hold_ff   <= csr_pwdata[7:0];
            slbc_pkg::REG_BOTTOM_HOLD: bottom_hold_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // flow control
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= take || (in_valid_ff && !advance);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_state_ff   <= req_ui_state;
         in_running_ff <= req_is_running;
         in_at_temp_ff <= req_at_temp;
      end
   end

   // tick evaluation
   always_comb begin
      purple    = (in_state_ff == slbc_pkg::UI_STANDBY);
      breathing = purple
               || (in_state_ff == slbc_pkg::UI_MENU && in_running_ff && !in_at_temp_ff)
               || (in_state_ff == slbc_pkg::UI_RUNNING && !in_at_temp_ff);

      phase_in     = phase_ff;
      hold_mid     = hold_ff;
      intensity_in = intensity_ff;
      blue_in      = blue_ff;
      orange_in    = orange_ff;

      unique case (phase_ff)
         slbc_pkg::PH_UP: begin
            if (intensity_ff != 8'hFF) intensity_in = intensity_ff + 8'd1;
         end
         slbc_pkg::PH_DOWN: begin
            if (intensity_ff != 8'd0) intensity_in = intensity_ff - 8'd1;
         end
         default: ;
      endcase

      product = intensity_in * duty_step_ff;
      if (product > 16'(slbc_pkg::FULL_SCALE)) duty = slbc_pkg::FULL_SCALE;
      else                                    duty = DW'(product);

      if (breathing) begin
         unique case (phase_ff)
            slbc_pkg::PH_UP: begin
               blue_in   = duty;
               orange_in = purple ? duty : '0;
               if (intensity_in >= ramp_top_ff) begin
                  phase_in = slbc_pkg::PH_PEAK;
                  hold_mid = 8'd0;
               end
            end
            slbc_pkg::PH_PEAK: begin
               if (hold_ff >= peak_hold_ff) begin
                  phase_in = slbc_pkg::PH_DOWN;
                  hold_mid = 8'd0;
               end
            end
            slbc_pkg::PH_DOWN: begin
               blue_in   = duty;
               orange_in = purple ? duty : '0;
               if (intensity_in == 8'd0) begin
                  phase_in = slbc_pkg::PH_BOTTOM;
                  hold_mid = 8'd0;
               end
            end
            slbc_pkg::PH_BOTTOM: begin
               if (hold_ff >= bottom_hold_ff) begin
                  phase_in = slbc_pkg::PH_UP;
                  hold_mid = 8'd0;
               end
            end
            default: ;
         endcase
      end else begin
         intensity_in = intensity_ff;
         if (in_state_ff == slbc_pkg::UI_ERROR) begin
            blue_in   = '0;
            orange_in = slbc_pkg::FULL_SCALE;
         end else if (in_state_ff == slbc_pkg::UI_MENU && !in_running_ff) begin
            blue_in   = slbc_pkg::FULL_SCALE;
            orange_in = slbc_pkg::FULL_SCALE;
         end else begin
            blue_in   = slbc_pkg::FULL_SCALE;
            orange_in = '0;
         end
      end

      if (breathing && hold_mid != 8'hFF) hold_in = hold_mid + 8'd1;
      else                                hold_in = hold_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= slbc_pkg::PH_UP;
         hold_ff      <= 8'd0;
         intensity_ff <= 8'd0;
         blue_ff      <= '0;
         orange_ff    <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         intensity_ff <= intensity_in;
         blue_ff      <= blue_in;
         orange_ff    <= orange_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_blue_duty   = slbc_pkg::OUT_WIDTH'(blue_ff);
   assign rsp_orange_duty = slbc_pkg::OUT_WIDTH'(orange_ff);

endmodule

### bench/testbench.sv
// Self-checking testbench for status_led_breathing_controller.
// Drives tick transactions and APB register writes and read-backs, predicts the duties in SV.
// Depends on slbc_pkg and the controller RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      slbc_pkg::ui_state_type ui;
      logic                   run;
      logic                   temp;
   } tick_type;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] orange;
   } duty_pair_type;

   typedef struct packed {
      tick_type      tick;
      logic          known;
      duty_pair_type duty;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_ui_state = slbc_pkg::UI_STANDBY;
   logic        req_is_running = 1'b0;
   logic        req_at_temp = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_blue_duty;
   logic [15:0] rsp_orange_duty;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   status_led_breathing_controller dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state and shadow registers
   logic [7:0]                 cfg_ramp_top, cfg_duty_step, cfg_peak_hold, cfg_bottom_hold;
   slbc_pkg::breath_phase_type phase;
   logic [7:0]                 hold_cnt, level;
   logic [15:0]                blue_lv, orange_lv;

   duty_pair_type pending_duties[$];
   int            fail_count = 0;
   int            send_idle = 0;
   int            recv_idle = 0;

   function automatic logic [15:0] breath_duty();
      logic [16:0] prod;
      prod = level * cfg_duty_step;
      if (prod > slbc_pkg::FULL_SCALE) prod = slbc_pkg::FULL_SCALE;
      return prod[15:0];
   endfunction

   function automatic void set_levels(logic [15:0] b, logic [15:0] o);
      blue_lv = b;
      orange_lv = o;
   endfunction

   function automatic void breathe(logic purple);
      case (phase)
         slbc_pkg::PH_UP: begin
            if (level != 8'hFF) level = level + 8'd1;
            set_levels(breath_duty(), purple ? breath_duty() : 16'h0);
            if (level >= cfg_ramp_top) begin
               phase = slbc_pkg::PH_PEAK;
               hold_cnt = 8'd0;
            end
         end
         slbc_pkg::PH_PEAK: begin
            if (hold_cnt >= cfg_peak_hold) begin
               phase = slbc_pkg::PH_DOWN;
               hold_cnt = 8'd0;
            end
         end
         slbc_pkg::PH_DOWN: begin
            if (level != 8'd0) level = level - 8'd1;
            set_levels(breath_duty(), purple ? breath_duty() : 16'h0);
            if (level == 8'd0) begin
               phase = slbc_pkg::PH_BOTTOM;
               hold_cnt = 8'd0;
            end
         end
         default: begin
            if (hold_cnt >= cfg_bottom_hold) begin
               phase = slbc_pkg::PH_UP;
               hold_cnt = 8'd0;
            end
         end
      endcase
      if (hold_cnt != 8'hFF) hold_cnt = hold_cnt + 8'd1;
   endfunction

   function automatic duty_pair_type led_tick(tick_type t);
      duty_pair_type d;
      case (t.ui)
         slbc_pkg::UI_STANDBY: breathe(1'b1);
         slbc_pkg::UI_ERROR:   set_levels(16'h0, slbc_pkg::FULL_SCALE);
         slbc_pkg::UI_MENU: begin
            if (!t.run) set_levels(slbc_pkg::FULL_SCALE, slbc_pkg::FULL_SCALE);
            else if (!t.temp) breathe(1'b0);
            else set_levels(slbc_pkg::FULL_SCALE, 16'h0);
         end
         default: begin
            if (!t.temp) breathe(1'b0);
            else set_levels(slbc_pkg::FULL_SCALE, 16'h0);
         end
      endcase
      d.blue = blue_lv;
      d.orange = orange_lv;
      return d;
   endfunction

   // Receiver side
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      duty_pair_type exp_d;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_duties.size() == 0) begin
            $display("%0t: unexpected result blue %0d orange %0d", $time,
                     rsp_blue_duty, rsp_orange_duty);
            fail_count++;
         end else begin
            exp_d = pending_duties.pop_front();
            if (rsp_blue_duty !== exp_d.blue) begin
               $display("%0t: blue_duty expected %0d got %0d", $time,
                        exp_d.blue, rsp_blue_duty);
               fail_count++;
            end
            if (rsp_orange_duty !== exp_d.orange) begin
               $display("%0t: orange_duty expected %0d got %0d", $time,
                        exp_d.orange, rsp_orange_duty);
               fail_count++;
            end
         end
      end
   end

   task automatic feed_tick(tick_type t, logic known, duty_pair_type known_duty);
      duty_pair_type d;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ui_state <= t.ui;
      req_is_running <= t.run;
      req_at_temp <= t.temp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      d = led_tick(t);
      pending_duties.push_back(known ? known_duty : d);
   endtask

   // Sender pauses until every pending duty has been returned
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_access(input slbc_pkg::reg_index_type idx, input logic wr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_breathing(logic [7:0] ramp, logic [7:0] step,
                                    logic [7:0] peak, logic [7:0] bottom);
      logic [7:0]              vals[4];
      logic [31:0]             rd;
      slbc_pkg::reg_index_type idx;
      vals = '{ramp, step, peak, bottom};
      drain();
      for (int i = 0; i < 4; i++) begin
         idx = slbc_pkg::reg_index_type'(i);
         csr_access(idx, 1'b1, {24'h0, vals[i]}, rd);
         csr_access(idx, 1'b0, 32'h0, rd);
         if (rd !== {24'h0, vals[i]}) begin
            $display("%0t: register %s expected %0d got %0d", $time, idx.name(),
                     vals[i], rd);
            fail_count++;
         end
      end
      cfg_ramp_top = ramp;
      cfg_duty_step = step;
      cfg_peak_hold = peak;
      cfg_bottom_hold = bottom;
   endtask

   // Rows 0..8 run with reset settings, the rest after the extreme setting
   script_row_type script [21] = '{
      '{'{slbc_pkg::UI_ERROR,   1'b0, 1'b0}, 1'b1, '{16'h0000, 16'hFFFF}},
      '{'{slbc_pkg::UI_MENU,    1'b0, 1'b0}, 1'b1, '{16'hFFFF, 16'hFFFF}},
      '{'{slbc_pkg::UI_MENU,    1'b1, 1'b1}, 1'b1, '{16'hFFFF, 16'h0000}},
      '{'{slbc_pkg::UI_RUNNING, 1'b0, 1'b1}, 1'b1, '{16'hFFFF, 16'h0000}},
      '{'{slbc_pkg::UI_STANDBY, 1'b0, 1'b0}, 1'b1, '{16'd2,    16'd2}},
      '{'{slbc_pkg::UI_RUNNING, 1'b0, 1'b0}, 1'b1, '{16'd4,    16'h0000}},
      '{'{slbc_pkg::UI_MENU,    1'b1, 1'b0}, 1'b1, '{16'd6,    16'h0000}},
      '{'{slbc_pkg::UI_ERROR,   1'b1, 1'b1}, 1'b1, '{16'h0000, 16'hFFFF}},
      '{'{slbc_pkg::UI_STANDBY, 1'b1, 1'b1}, 1'b1, '{16'd8,    16'd8}},
      '{'{slbc_pkg::UI_STANDBY, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_STANDBY, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_RUNNING, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_RUNNING, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_MENU,    1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_STANDBY, 1'b0, 1'b1}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_MENU,    1'b0, 1'b1}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_STANDBY, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_STANDBY, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_RUNNING, 1'b1, 1'b1}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_STANDBY, 1'b1, 1'b0}, 1'b0, '{16'h0, 16'h0}},
      '{'{slbc_pkg::UI_STANDBY, 1'b0, 1'b0}, 1'b0, '{16'h0, 16'h0}}
   };

   initial begin
      logic [7:0] blk_cfg[8][4];
      int         blk_items;
      tick_type   t;
      int         pick;
      cfg_ramp_top = slbc_pkg::RAMP_TOP_RESET;
      cfg_duty_step = slbc_pkg::DUTY_STEP_RESET;
      cfg_peak_hold = slbc_pkg::PEAK_HOLD_RESET;
      cfg_bottom_hold = slbc_pkg::BOTTOM_HOLD_RESET;
      phase = slbc_pkg::PH_UP;
      hold_cnt = 8'd0;
      level = 8'd0;
      blue_lv = 16'h0;
      orange_lv = 16'h0;
      for (int b = 0; b < 8; b++) begin
         blk_cfg[b] = '{8'($urandom_range(16, 1)), 8'($urandom_range(255)),
                        8'($urandom_range(10)), 8'($urandom_range(10))};
      end
      blk_cfg[1] = '{8'd255, 8'd255, 8'd0, 8'd0};
      blk_cfg[2] = '{8'd1, 8'd255, 8'd255, 8'd0};
      blk_cfg[3] = '{8'd0, 8'd0, 8'd0, 8'd255};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 26;
      recv_idle = 62;
      for (int i = 0; i < 9; i++) feed_tick(script[i].tick, script[i].known, script[i].duty);
      program_breathing(8'd0, 8'd255, 8'd0, 8'd0);
      for (int i = 9; i < 21; i++) feed_tick(script[i].tick, script[i].known, script[i].duty);

      for (int b = 0; b < 8; b++) begin
         send_idle = (b < 3) ? 26 : (b < 6) ? 62 : 0;
         recv_idle = (b < 3) ? 62 : (b < 6) ? 26 : 0;
         program_breathing(blk_cfg[b][0], blk_cfg[b][1], blk_cfg[b][2], blk_cfg[b][3]);
         blk_items = (b == 1 || b == 2) ? 400 : 175;
         for (int n = 0; n < blk_items; n++) begin
            pick = $urandom_range(99);
            t.run = 1'($urandom_range(1));
            t.temp = 1'($urandom_range(1));
            if (pick < 40) begin
               t.ui = slbc_pkg::UI_STANDBY;
            end else if (pick < 50) begin
               t.ui = slbc_pkg::UI_ERROR;
            end else if (pick < 60) begin
               t.ui = slbc_pkg::UI_MENU;
               t.run = 1'b0;
            end else begin
               t.ui = $urandom_range(1) ? slbc_pkg::UI_RUNNING : slbc_pkg::UI_MENU;
               t.temp = (pick >= 82);
               if (t.ui == slbc_pkg::UI_MENU) t.run = 1'b1;
            end
            feed_tick(t, 1'b0, '0);
            if ($urandom_range(99) == 0) drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS status_led_breathing_controller");
      end else begin
         $display("FAIL status_led_breathing_controller");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL status_led_breathing_controller");
      $finish;
   end

endmodule

### sim.f
rtl/core/slbc_pkg.sv
rtl/core/status_led_breathing_controller.sv
bench/testbench.sv
